FILE: design/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, codes and defaults of the chained hash table engine.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_MAX_BUCKETS = 1024;
    localparam int DEF_KEY_WIDTH   = 32;

    localparam int REQ_W   = 3;
    localparam int CODE_W  = 32;
    localparam int KEY_W   = 32;
    localparam int POS_W   = 10;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = 10;
    localparam int TOTAL_W = 11;
    localparam int BCNT_W  = 11;

    typedef enum logic [REQ_W-1:0] {
        REQ_FIND      = 3'd0,
        REQ_INS_UNIQ  = 3'd1,
        REQ_INS_MULTI = 3'd2,
        REQ_REM_KEY   = 3'd3,
        REQ_REM_POS   = 3'd4,
        REQ_READ_POS  = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_POS   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_WLOAD,
        S_WTEST,
        S_WCMP,
        S_TAKE,
        S_TAKE2,
        S_LINK,
        S_PRD,
        S_UNLINK,
        S_REL,
        S_RESP
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LATCH,
        OP_DIV_REQ,
        OP_DIV_STEP,
        OP_BKT_RD,
        OP_WLOAD,
        OP_WTEST,
        OP_WCMP,
        OP_TAKE_RD,
        OP_TAKE_WR,
        OP_LINK,
        OP_POS_RD,
        OP_POS_LATCH,
        OP_UNLINK,
        OP_RELEASE
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    rsp;     // load the result register this cycle
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic             clr_done;
        logic             div_done;
        logic             walk_more;
        logic             match;
        logic             free_null;
        logic             pos_bad;
        logic             ent_valid;
        logic [REQ_W-1:0] req_type;
    } t_dp_stat;

endpackage

FILE: design/cht_req_if.sv
// ----------------------------------------------------------------------------
// cht_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface cht_req_if import cht_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CODE_W-1:0] hash_code;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  position;

    modport source (output valid, req_type, hash_code, key, position, input ready);
    modport sink   (input valid, req_type, hash_code, key, position, output ready);
endinterface

FILE: design/cht_rsp_if.sv
// ----------------------------------------------------------------------------
// cht_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface cht_rsp_if import cht_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   entry_index;
    logic [KEY_W-1:0]   entry_key;
    logic [CODE_W-1:0]  entry_code;
    logic               entry_valid;
    logic [TOTAL_W-1:0] item_total;
    logic               is_empty;
    logic               is_full;

    modport source (output valid, status, entry_index, entry_key, entry_code, entry_valid,
                    item_total, is_empty, is_full, input ready);
    modport sink   (input valid, status, entry_index, entry_key, entry_code, entry_valid,
                    item_total, is_empty, is_full, output ready);
endinterface

FILE: design/cht_dpath.sv
// ----------------------------------------------------------------------------
// cht_dpath
// Datapath: entry and bucket memories, bucket divider, chain walk registers,
// free list, counters and the result register.
// ----------------------------------------------------------------------------
module cht_dpath
    import cht_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_cfg_we,
    input  logic [BCNT_W-1:0]  i_cfg_wdata,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [CODE_W-1:0]  i_hash_code,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [POS_W-1:0]   i_position,
    output logic [STAT_W-1:0]  o_status,
    output logic [IDX_W-1:0]   o_entry_index,
    output logic [KEY_W-1:0]   o_entry_key,
    output logic [CODE_W-1:0]  o_entry_code,
    output logic               o_entry_valid,
    output logic [TOTAL_W-1:0] o_item_total,
    output logic               o_is_empty,
    output logic               o_is_full
);

    localparam int IW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LW     = IW + 1;
    localparam int BW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SW     = $clog2(MAX_ENTRIES + 1);
    localparam int KW     = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int CLR_N  = (MAX_ENTRIES > MAX_BUCKETS) ? MAX_ENTRIES : MAX_BUCKETS;
    localparam int CW     = $clog2(CLR_N);
    localparam int BC_RST = (MAX_BUCKETS > 2047) ? 2047 : MAX_BUCKETS;
    localparam int DIV_N  = CODE_W;
    localparam int DCW    = $clog2(DIV_N + 1);
    localparam logic [LW-1:0] NIL = '1;

    // memories
    logic              m_valid [MAX_ENTRIES];
    logic [CODE_W-1:0] m_code  [MAX_ENTRIES];
    logic [KW-1:0]     m_key   [MAX_ENTRIES];
    logic [LW-1:0]     m_next  [MAX_ENTRIES];
    logic [LW-1:0]     m_prev  [MAX_ENTRIES];
    logic [LW-1:0]     m_head  [MAX_BUCKETS];
    logic [SW-1:0]     m_size  [MAX_BUCKETS];

    logic              q_valid;
    logic [CODE_W-1:0] q_code;
    logic [KW-1:0]     q_key;
    logic [LW-1:0]     q_next, q_prev, q_head;
    logic [SW-1:0]     q_size;

    // registers
    logic [BCNT_W-1:0] r_bcnt;
    logic [REQ_W-1:0]  r_type,  n_type;
    logic [CODE_W-1:0] r_code,  n_code;
    logic [KW-1:0]     r_key,   n_key;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [CODE_W-1:0] r_dvd,   n_dvd;
    logic [BCNT_W-1:0] r_rem,   n_rem;
    logic [DCW-1:0]    r_dcnt,  n_dcnt;
    logic [LW-1:0]     r_head,  n_head;
    logic [SW-1:0]     r_size,  n_size;
    logic [LW-1:0]     r_walk,  n_walk;
    logic [SW-1:0]     r_n,     n_n;
    logic [IW-1:0]     r_node,  n_node;
    logic [LW-1:0]     r_p,     n_p;
    logic [LW-1:0]     r_nx,    n_nx;
    logic [KW-1:0]     r_ekey,  n_ekey;
    logic [CODE_W-1:0] r_ecode, n_ecode;
    logic              r_evld,  n_evld;
    logic [LW-1:0]     r_free,  n_free;
    logic [SW-1:0]     r_total, n_total;
    logic [CW-1:0]     r_clr,   n_clr;

    logic [BCNT_W-1:0] bkt_n;
    logic [BCNT_W:0]   dv_t;
    logic [IW-1:0]     ea;
    logic [BW-1:0]     ba;
    logic              match;
    logic              clr_e, clr_b;
    logic              fields_ok;

    logic              we_valid, wd_valid;
    logic [IW-1:0]     wa_valid;
    logic              we_code;
    logic [IW-1:0]     wa_code;
    logic [CODE_W-1:0] wd_code;
    logic              we_key;
    logic              we_next, we_prev;
    logic [IW-1:0]     wa_next, wa_prev;
    logic [LW-1:0]     wd_next, wd_prev;
    logic              we_bkt;
    logic [BW-1:0]     wa_bkt;
    logic [LW-1:0]     wd_head;
    logic [SW-1:0]     wd_size;

    // bucket count as used: zero acts as one, above the table size as the table size
    always_comb begin
        if (r_bcnt == '0) begin
            bkt_n = BCNT_W'(1);
        end else if (32'(r_bcnt) > 32'(MAX_BUCKETS)) begin
            bkt_n = BCNT_W'(BC_RST);
        end else begin
            bkt_n = r_bcnt;
        end
    end

    assign match = q_valid && (q_code == r_code) && (q_key == r_key);
    assign clr_e = 32'(r_clr) < 32'(MAX_ENTRIES);
    assign clr_b = 32'(r_clr) < 32'(MAX_BUCKETS);
    assign ba    = BW'(r_rem);

    always_comb begin
        case (i_cmd.op)
            OP_TAKE_RD: ea = IW'(r_free);
            OP_POS_RD:  ea = IW'(r_pos);
            default:    ea = IW'(r_walk);
        endcase
    end

    assign o_stat.clr_done  = r_clr == CW'(CLR_N - 1);
    assign o_stat.div_done  = r_dcnt == '0;
    assign o_stat.walk_more = (32'(r_walk) < 32'(MAX_ENTRIES)) && (r_n < r_size);
    assign o_stat.match     = match;
    assign o_stat.free_null = 32'(r_free) >= 32'(MAX_ENTRIES);
    assign o_stat.pos_bad   = 32'(r_pos) >= 32'(MAX_ENTRIES);
    assign o_stat.ent_valid = q_valid;
    assign o_stat.req_type  = r_type;

    // register next values
    always_comb begin
        dv_t    = {r_rem, r_dvd[CODE_W-1]};
        n_type  = r_type;
        n_code  = r_code;
        n_key   = r_key;
        n_pos   = r_pos;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_dcnt  = r_dcnt;
        n_head  = r_head;
        n_size  = r_size;
        n_walk  = r_walk;
        n_n     = r_n;
        n_node  = r_node;
        n_p     = r_p;
        n_nx    = r_nx;
        n_ekey  = r_ekey;
        n_ecode = r_ecode;
        n_evld  = r_evld;
        n_free  = r_free;
        n_total = r_total;
        n_clr   = r_clr;
        case (i_cmd.op)
            OP_CLEAR: begin
                n_clr = r_clr + CW'(1);
            end
            OP_LATCH: begin
                n_type = i_req_type;
                n_code = i_hash_code;
                n_key  = i_key[KW-1:0];
                n_pos  = i_position;
            end
            OP_DIV_REQ: begin
                n_dvd  = r_code;
                n_rem  = '0;
                n_dcnt = DCW'(DIV_N);
            end
            OP_DIV_STEP: begin
                // restoring division, one quotient bit per cycle
                if (dv_t >= {1'b0, bkt_n}) begin
                    dv_t = dv_t - {1'b0, bkt_n};
                end
                n_rem  = dv_t[BCNT_W-1:0];
                n_dvd  = {r_dvd[CODE_W-2:0], 1'b0};
                n_dcnt = r_dcnt - DCW'(1);
            end
            OP_WLOAD: begin
                n_head = q_head;
                n_size = q_size;
                n_walk = q_head;
                n_n    = '0;
            end
            OP_WCMP: begin
                if (match) begin
                    n_node  = IW'(r_walk);
                    n_p     = q_prev;
                    n_nx    = q_next;
                    n_ekey  = q_key;
                    n_ecode = q_code;
                    n_evld  = 1'b1;
                end else begin
                    n_walk = q_next;
                    n_n    = r_n + SW'(1);
                end
            end
            OP_TAKE_WR: begin
                n_node  = IW'(r_free);
                n_free  = q_next;
                n_total = r_total + SW'(1);
                n_ekey  = r_key;
                n_ecode = r_code;
                n_evld  = 1'b1;
            end
            OP_POS_LATCH: begin
                n_node  = IW'(r_pos);
                n_p     = q_prev;
                n_nx    = q_next;
                n_ekey  = q_key;
                n_ecode = q_code;
                n_evld  = q_valid;
                n_dvd   = q_code;
                n_rem   = '0;
                n_dcnt  = DCW'(DIV_N);
            end
            OP_UNLINK: begin
                n_evld = 1'b0;
            end
            OP_RELEASE: begin
                n_free = LW'(r_node);
                if (r_total != '0) begin
                    n_total = r_total - SW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // memory write ports
    always_comb begin
        we_valid = 1'b0;
        wa_valid = r_node;
        wd_valid = 1'b0;
        we_code  = 1'b0;
        wa_code  = r_node;
        wd_code  = '0;
        we_key   = 1'b0;
        we_next  = 1'b0;
        wa_next  = r_node;
        wd_next  = NIL;
        we_prev  = 1'b0;
        wa_prev  = r_node;
        wd_prev  = NIL;
        we_bkt   = 1'b0;
        wa_bkt   = ba;
        wd_head  = NIL;
        wd_size  = '0;
        case (i_cmd.op)
            OP_CLEAR: begin
                we_valid = clr_e;
                wa_valid = r_clr[IW-1:0];
                we_code  = clr_e;
                wa_code  = r_clr[IW-1:0];
                we_next  = clr_e;
                wa_next  = r_clr[IW-1:0];
                if (32'(r_clr) + 32'd1 < 32'(MAX_ENTRIES)) begin
                    wd_next = LW'(32'(r_clr) + 32'd1);
                end
                we_prev  = clr_e;
                wa_prev  = r_clr[IW-1:0];
                we_bkt   = clr_b;
                wa_bkt   = r_clr[BW-1:0];
            end
            OP_TAKE_WR: begin
                we_valid = 1'b1;
                wa_valid = IW'(r_free);
                wd_valid = 1'b1;
                we_code  = 1'b1;
                wa_code  = IW'(r_free);
                wd_code  = r_code;
                we_key   = 1'b1;
                we_next  = 1'b1;
                wa_next  = IW'(r_free);
                wd_next  = (r_size != '0) ? r_head : NIL;
                we_prev  = 1'b1;
                wa_prev  = IW'(r_free);
            end
            OP_LINK: begin
                we_prev = (r_size != '0) && (32'(r_head) < 32'(MAX_ENTRIES));
                wa_prev = IW'(r_head);
                wd_prev = LW'(r_node);
                we_bkt  = 1'b1;
                wd_head = LW'(r_node);
                wd_size = (32'(r_size) < 32'(MAX_ENTRIES)) ? r_size + SW'(1) : r_size;
            end
            OP_UNLINK: begin
                we_next = 32'(r_p) < 32'(MAX_ENTRIES);
                wa_next = IW'(r_p);
                wd_next = r_nx;
                we_prev = 32'(r_nx) < 32'(MAX_ENTRIES);
                wa_prev = IW'(r_nx);
                wd_prev = r_p;
                we_bkt  = 1'b1;
                wd_head = (r_head == LW'(r_node)) ? r_nx : r_head;
                wd_size = (r_size != '0) ? r_size - SW'(1) : r_size;
            end
            OP_RELEASE: begin
                we_valid = 1'b1;
                we_code  = 1'b1;
                we_next  = 1'b1;
                wd_next  = r_free;
                we_prev  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_valid) m_valid[wa_valid] <= wd_valid;
        if (we_code)  m_code[wa_code]   <= wd_code;
        if (we_key)   m_key[IW'(r_free)] <= r_key;
        if (we_next)  m_next[wa_next]   <= wd_next;
        if (we_prev)  m_prev[wa_prev]   <= wd_prev;
        if (we_bkt) begin
            m_head[wa_bkt] <= wd_head;
            m_size[wa_bkt] <= wd_size;
        end
        q_valid <= m_valid[ea];
        q_code  <= m_code[ea];
        q_key   <= m_key[ea];
        q_next  <= m_next[ea];
        q_prev  <= m_prev[ea];
        q_head  <= m_head[ba];
        q_size  <= m_size[ba];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt  <= BCNT_W'(BC_RST);
            r_dcnt  <= '0;
            r_free  <= '0;
            r_total <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_bcnt <= i_cfg_wdata;
            end
            r_dcnt  <= n_dcnt;
            r_free  <= n_free;
            r_total <= n_total;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type  <= n_type;
        r_code  <= n_code;
        r_key   <= n_key;
        r_pos   <= n_pos;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_head  <= n_head;
        r_size  <= n_size;
        r_walk  <= n_walk;
        r_n     <= n_n;
        r_node  <= n_node;
        r_p     <= n_p;
        r_nx    <= n_nx;
        r_ekey  <= n_ekey;
        r_ecode <= n_ecode;
        r_evld  <= n_evld;
    end

    // result register
    assign fields_ok = (i_cmd.status == ST_OK) || (i_cmd.status == ST_DUPLICATE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp) begin
            o_status      <= i_cmd.status;
            o_entry_index <= fields_ok ? IDX_W'(n_node) : '0;
            o_entry_key   <= fields_ok ? KEY_W'(n_ekey) : '0;
            o_entry_code  <= fields_ok ? n_ecode : '0;
            o_entry_valid <= fields_ok ? n_evld : 1'b0;
            o_item_total  <= TOTAL_W'(n_total);
            o_is_empty    <= n_total == '0;
            o_is_full     <= 32'(n_total) >= 32'(MAX_ENTRIES);
        end
    end

`ifndef SYNTHESIS
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= 32'(MAX_ENTRIES))
        else $error("valid count beyond table size");
    a_free_vs_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_free) >= 32'(MAX_ENTRIES)) == (32'(r_total) == 32'(MAX_ENTRIES)))
        else $error("free list and valid count disagree");
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bkt_n != '0) && (32'(bkt_n) <= 32'(MAX_BUCKETS)))
        else $error("bucket divisor out of range");
`endif

endmodule

FILE: design/cht_ctrl.sv
// ----------------------------------------------------------------------------
// cht_ctrl
// Controller: sequences clear pass, divide, chain walk, take/link and
// unlink/release steps, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module cht_ctrl
    import cht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = r_state == S_IDLE;
    assign o_rsp_valid = r_state == S_RESP;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.req_type) inside
                    REQ_FIND, REQ_INS_UNIQ, REQ_INS_MULTI, REQ_REM_KEY: n_state = S_DIV;
                    REQ_REM_POS, REQ_READ_POS: n_state = i_stat.pos_bad ? S_RESP : S_PRD;
                    default: n_state = S_RESP;
                endcase
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_WLOAD;
            end
            S_WLOAD: begin
                case (i_stat.req_type)
                    REQ_INS_MULTI: n_state = S_TAKE;
                    REQ_REM_POS:   n_state = S_UNLINK;
                    default:       n_state = S_WTEST;
                endcase
            end
            S_WTEST: begin
                if (i_stat.walk_more) begin
                    n_state = S_WCMP;
                end else if (i_stat.req_type == REQ_INS_UNIQ) begin
                    n_state = S_TAKE;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_WCMP: begin
                if (!i_stat.match) begin
                    n_state = S_WTEST;
                end else if (i_stat.req_type == REQ_REM_KEY) begin
                    n_state = S_UNLINK;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_TAKE:   n_state = i_stat.free_null ? S_RESP : S_TAKE2;
            S_TAKE2:  n_state = S_LINK;
            S_LINK:   n_state = S_RESP;
            S_PRD: begin
                if (i_stat.req_type == REQ_REM_POS && i_stat.ent_valid) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_UNLINK: n_state = S_REL;
            S_REL:    n_state = S_RESP;
            S_RESP: begin
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.op     = OP_NOP;
        o_cmd.rsp    = 1'b0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_CLEAR: o_cmd.op = OP_CLEAR;
            S_IDLE: begin
                if (i_req_valid) o_cmd.op = OP_LATCH;
            end
            S_DISPATCH: begin
                case (i_stat.req_type) inside
                    REQ_FIND, REQ_INS_UNIQ, REQ_INS_MULTI, REQ_REM_KEY: o_cmd.op = OP_DIV_REQ;
                    REQ_REM_POS, REQ_READ_POS: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.rsp    = 1'b1;
                            o_cmd.status = ST_BAD_POS;
                        end else begin
                            o_cmd.op = OP_POS_RD;
                        end
                    end
                    default: begin
                        o_cmd.rsp    = 1'b1;
                        o_cmd.status = ST_NOT_FOUND;
                    end
                endcase
            end
            S_DIV:   o_cmd.op = i_stat.div_done ? OP_BKT_RD : OP_DIV_STEP;
            S_WLOAD: o_cmd.op = OP_WLOAD;
            S_WTEST: begin
                if (i_stat.walk_more) begin
                    o_cmd.op = OP_WTEST;
                end else if (i_stat.req_type != REQ_INS_UNIQ) begin
                    o_cmd.rsp    = 1'b1;
                    o_cmd.status = ST_NOT_FOUND;
                end
            end
            S_WCMP: begin
                o_cmd.op = OP_WCMP;
                if (i_stat.match && i_stat.req_type == REQ_FIND) begin
                    o_cmd.rsp = 1'b1;
                end else if (i_stat.match && i_stat.req_type == REQ_INS_UNIQ) begin
                    o_cmd.rsp    = 1'b1;
                    o_cmd.status = ST_DUPLICATE;
                end
            end
            S_TAKE: begin
                if (i_stat.free_null) begin
                    o_cmd.rsp    = 1'b1;
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.op = OP_TAKE_RD;
                end
            end
            S_TAKE2: o_cmd.op = OP_TAKE_WR;
            S_LINK: begin
                o_cmd.op  = OP_LINK;
                o_cmd.rsp = 1'b1;
            end
            S_PRD: begin
                o_cmd.op = OP_POS_LATCH;
                if (i_stat.req_type == REQ_READ_POS) begin
                    o_cmd.rsp = 1'b1;
                end else if (!i_stat.ent_valid) begin
                    o_cmd.rsp    = 1'b1;
                    o_cmd.status = ST_BAD_POS;
                end
            end
            S_UNLINK: o_cmd.op = OP_UNLINK;
            S_REL: begin
                o_cmd.op  = OP_RELEASE;
                o_cmd.rsp = 1'b1;
            end
            S_RESP: o_cmd.op = OP_NOP;
            default: o_cmd.op = OP_NOP;
        endcase
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_rsp_valid))
        else $error("request taken while a result is pending");
    a_rsp_enters_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rsp |=> r_state == S_RESP)
        else $error("result loaded without presenting it");
    a_clear_first: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR) && !o_req_ready)
        else $error("requests taken before the clearing pass");
`endif

endmodule

FILE: design/chained_hash_table_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Fixed-size chained hash table with a LIFO free list.
//
//   channel   dir  handshake            carries
//   i_req     in   valid/ready          req_type, hash_code, key, position
//   o_rsp     out  valid/ready          status, entry fields, item_total, flags
//   i_cfg_*   in   write enable only    bucket_count
//
// One request at a time. Hash requests run the bucket divide and bucket read;
// all but multi-inserts then walk the chain. Inserts take and link an entry
// (unique ones only on a miss), removals unlink and release the match.
// Position requests read the entry; remove by position adds the divide and unlink.
// After reset a clearing pass over max(MAX_ENTRIES, MAX_BUCKETS) addresses runs
// before the first request is taken.
// The result holds in its register until taken; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module chained_hash_table_engine
    import cht_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cht_req_if.sink           i_req,
    cht_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic [BCNT_W-1:0] i_cfg_wdata
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    cht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    cht_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_BUCKETS (MAX_BUCKETS),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req.req_type),
        .i_hash_code   (i_req.hash_code),
        .i_key         (i_req.key),
        .i_position    (i_req.position),
        .o_status      (o_rsp.status),
        .o_entry_index (o_rsp.entry_index),
        .o_entry_key   (o_rsp.entry_key),
        .o_entry_code  (o_rsp.entry_code),
        .o_entry_valid (o_rsp.entry_valid),
        .o_item_total  (o_rsp.item_total),
        .o_is_empty    (o_rsp.is_empty),
        .o_is_full     (o_rsp.is_full)
    );

endmodule
